### src/wrm_pkg.sv
// Shared constants, types and register codes for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wrm_pkg;

   // Longest pattern the row memory can hold.
   localparam int MaxPattern = 32;

   // Pattern register file: four 64-bit registers of eight bytes each.
   localparam int PatWords = 4;
   localparam int WordW    = 64;
   localparam int PatBytes = 32;
   localparam int PatIdxW  = 5;

   localparam int LenW    = 6;
   localparam int CsrIdxW = 3;

   // Position in the row (0 to MaxPattern) and row memory address.
   localparam int PosW  = $clog2(MaxPattern + 1);
   localparam int AddrW = $clog2(MaxPattern);

   localparam logic [7:0] StarByte = 8'h2A;
   localparam logic [7:0] DotByte  = 8'h2E;

   typedef logic [PosW-1:0]  pos_type;
   typedef logic [AddrW-1:0] addr_type;
   typedef logic [7:0]       byte_type;

   typedef enum logic [CsrIdxW-1:0] {
      CsrLength = 3'd0,
      CsrBytes0 = 3'd1,
      CsrBytes1 = 3'd2,
      CsrBytes2 = 3'd3,
      CsrBytes3 = 3'd4
   } csr_idx_type;

   // What the pattern registers show the scan sequencer.
   typedef struct packed {
      pos_type  used_len;
      byte_type pos_byte;
   } pat_view_type;

endpackage

### src/wrm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module wrm_ram #(
   parameter int Width = 1,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wrm_pattern_regs.sv
// Pattern length and pattern byte registers with a per-position byte lookup.
`timescale 1ns / 1ps

module wrm_pattern_regs
   import wrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [WordW-1:0]   csr_wdata,
   input  addr_type           pat_pos,
   output pat_view_type       pat_view
);

   localparam int IdxW = (AddrW > PatIdxW) ? AddrW : PatIdxW;

   logic [LenW-1:0]  len_ff;
   logic [WordW-1:0] word_ff [PatWords];
   logic [IdxW-1:0]  pos_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int w = 0; w < PatWords; w++) begin
            word_ff[w] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CsrLength: len_ff     <= csr_wdata[LenW-1:0];
            CsrBytes0: word_ff[0] <= csr_wdata;
            CsrBytes1: word_ff[1] <= csr_wdata;
            CsrBytes2: word_ff[2] <= csr_wdata;
            CsrBytes3: word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Lengths above the row size are clamped; bytes beyond the registers read as zero.
   always_comb begin
      pos_x = IdxW'(pat_pos);
      if (int'(len_ff) > MaxPattern) begin
         pat_view.used_len = PosW'(MaxPattern);
      end else begin
         pat_view.used_len = PosW'(len_ff);
      end
      if (int'(pos_x) < PatBytes) begin
         pat_view.pos_byte = word_ff[pos_x[PatIdxW-1:3]][{pos_x[2:0], 3'b000} +: 8];
      end else begin
         pat_view.pos_byte = '0;
      end
   end

endmodule

### src/wrm_scan.sv
// Row update sequencer: walks the pattern positions through the row memory.
`timescale 1ns / 1ps

module wrm_scan
   import wrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  byte_type     text_byte,
   input  logic         first_byte,
   input  logic         last_byte,
   input  logic         empty_text,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         matched,
   output logic         final_result,
   output addr_type     pat_pos,
   input  pat_view_type pat_view
);

   typedef enum logic [1:0] {
      StIdle,
      StScan,
      StDone
   } state_type;

   state_type state_ff;
   pos_type   pos_ff;        // row position whose stored bit arrives this cycle
   pos_type   valid_cnt_ff;  // row bits above this count read as zero
   byte_type  char_ff;
   byte_type  prev_pat_ff;   // pattern byte one position back
   logic      first_ff;
   logic      last_ff;
   logic      empty_ff;
   logic      prev_lo_ff;    // old row bit one position back
   logic      cur_m1_ff;
   logic      cur_m2_ff;
   logic      empty_m1_ff;   // empty-text row, one and two positions back
   logic      empty_m2_ff;
   logic      match_ff;
   logic      rsp_valid_ff;
   logic      rsp_match_ff;
   logic      rsp_final_ff;

   pos_type   pos_m1;
   addr_type  rd_addr;
   logic      rd_bit;
   logic      wr_en;
   byte_type  pat_byte;
   logic      is_star;
   logic      lit_hit;
   logic      rep_hit;
   logic      empty_bit;
   logic      prev_bit;
   logic      cur_bit;
   logic      last_pos;
   logic      out_free;
   logic      load_rsp;
   logic      accept;

   assign pos_m1   = pos_ff - 1'b1;
   assign pat_pos  = pos_m1[AddrW-1:0];
   assign pat_byte = pat_view.pos_byte;
   assign rd_addr  = (state_ff == StScan) ? pos_ff[AddrW-1:0] : '0;
   assign wr_en    = (state_ff == StScan) && !empty_ff;
   assign accept   = (state_ff == StIdle) && req_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_rsp = (state_ff == StDone) && out_free;
   assign last_pos = (pos_ff == pat_view.used_len);

   wrm_ram #(
      .Width (1),
      .Depth (MaxPattern)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_m1[AddrW-1:0]),
      .wr_data (cur_bit),
      .rd_addr (rd_addr),
      .rd_data (rd_bit)
   );

   // One cell of the row: the new bit depends on the old bit here and one back,
   // and on the new bit two back for a starred byte.
   always_comb begin
      is_star   = (pat_byte == StarByte);
      lit_hit   = (char_ff == pat_byte) || (pat_byte == DotByte);
      rep_hit   = (char_ff == prev_pat_ff) || (prev_pat_ff == DotByte);
      empty_bit = empty_m2_ff && is_star;
      if (first_ff) begin
         prev_bit = empty_bit;
      end else begin
         prev_bit = (pos_ff <= valid_cnt_ff) && rd_bit;
      end
      if (is_star) begin
         // A star at the first position has nothing to repeat and never matches.
         cur_bit = (pos_ff != pos_type'(1)) && ((prev_bit && rep_hit) || cur_m2_ff);
      end else begin
         cur_bit = lit_hit && prev_lo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         valid_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A result taken at the same edge as a new one is loaded stays valid.
         if (rsp_valid_ff && rsp_ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            StIdle: begin
               if (accept) begin
                  char_ff     <= text_byte;
                  first_ff    <= first_byte;
                  last_ff     <= last_byte;
                  empty_ff    <= empty_text;
                  pos_ff      <= pos_type'(1);
                  prev_lo_ff  <= first_byte;
                  cur_m1_ff   <= 1'b0;
                  cur_m2_ff   <= 1'b0;
                  empty_m1_ff <= 1'b1;
                  empty_m2_ff <= 1'b0;
                  if (pat_view.used_len == '0) begin
                     match_ff <= empty_text;
                     if (!empty_text) begin
                        valid_cnt_ff <= '0;
                     end
                     state_ff <= StDone;
                  end else begin
                     state_ff <= StScan;
                  end
               end
            end
            StScan: begin
               prev_lo_ff  <= prev_bit;
               cur_m2_ff   <= cur_m1_ff;
               cur_m1_ff   <= cur_bit;
               empty_m2_ff <= empty_m1_ff;
               empty_m1_ff <= empty_bit;
               prev_pat_ff <= pat_byte;
               pos_ff      <= pos_ff + 1'b1;
               if (last_pos) begin
                  match_ff <= empty_ff ? empty_bit : cur_bit;
                  if (!empty_ff) begin
                     valid_cnt_ff <= pat_view.used_len;
                  end
                  state_ff <= StDone;
               end
            end
            StDone: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_match_ff <= match_ff;
                  rsp_final_ff <= last_ff || empty_ff;
                  state_ff     <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   assign req_ready    = (state_ff == StIdle);
   assign rsp_valid    = rsp_valid_ff;
   assign matched      = rsp_match_ff;
   assign final_result = rsp_final_ff;

endmodule

### src/wildcard_regex_matcher_unit.sv
// Top level of the wildcard pattern matcher: stream ports, registers and row sequencer.
`timescale 1ns / 1ps

// This block matches a text, one byte per word on the req_ stream, against a
// stored pattern of literal bytes, '.' for any byte and "x*" for zero or more
// of x. It keeps one row of match bits, one per pattern position, in a small
// one-bit-wide synchronous RAM; for each text byte a sequencer walks the
// positions in order, reading the old bit of one position while writing the
// new bit of the position before it, so no two accesses ever meet at the same
// entry. Every req_ word yields exactly one rsp_ word: bit 0 of rsp_tdata says
// whether the whole pattern matches the text seen since the last word marked
// as a first byte, and rsp_tlast marks the result for the last byte of the
// text or for a word flagged as empty text. A word is accepted in the idle
// state, then the scan state walks the RAM one pattern position at a time
// (no walk for an empty pattern), then the done state hands the result to the
// output register. The next word is accepted while the previous result still
// waits in that register. Row bits above the length used by the last byte
// read as zero through a fill count, so no clearing pass follows reset.
// Pattern registers may be written only while the block is idle; a write
// takes effect at once, and a text in progress continues against the new
// pattern. A leading '*' never matches.

module wildcard_regex_matcher_unit
   import wrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] text_byte
   input  logic [1:0]         req_tuser,   // [0] first_byte, [1] empty_text
   input  logic               req_tlast,   // last_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [0] matched, [7:1] zero
   output logic               rsp_tlast,   // final_result
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [WordW-1:0]   csr_wdata
);

   addr_type     pat_pos;
   pat_view_type pat_view;
   logic         matched;

   wrm_pattern_regs u_pattern_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pat_pos   (pat_pos),
      .pat_view  (pat_view)
   );

   wrm_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .text_byte    (req_tdata),
      .first_byte   (req_tuser[0]),
      .last_byte    (req_tlast),
      .empty_text   (req_tuser[1]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .matched      (matched),
      .final_result (rsp_tlast),
      .pat_pos      (pat_pos),
      .pat_view     (pat_view)
   );

   assign rsp_tdata = {7'b0000000, matched};

endmodule

### src/wrm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to its top level.
`timescale 1ns / 1ps

module wrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // One word is worked on at a time, so the input closes after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input stayed open after accepting a word");

   // Reset leaves no result pending and the input open.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the result side");

   // Only the match bit is ever set in the result data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0000000)
      else $error("result padding bits set");

endmodule

bind wildcard_regex_matcher_unit wrm_checker u_wrm_checker (.*);

### sim/wildcard_match_checker.sv
// Checker that predicts and compares every result word of the wildcard pattern matcher.
`timescale 1ns / 1ps

module wildcard_match_checker
   import wrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] text_byte
   input  logic [1:0]         req_tuser,   // [0] first_byte, [1] empty_text
   input  logic               req_tlast,   // last_byte
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [7:0]         rsp_tdata,   // [0] matched, [7:1] zero
   input  logic               rsp_tlast,   // final_result
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [WordW-1:0]   csr_wdata,
   output int                 error_count,
   output int                 pending,
   output int                 hit_count
);

   typedef struct packed {
      logic matched;
      logic final_result;
   } match_result_type;

   typedef logic [MaxPattern:0] row_type;

   logic [LenW-1:0]  length_reg;
   logic [WordW-1:0] pattern_words [PatWords];
   row_type          match_row;
   match_result_type expected_results [$];
   int               errors = 0;
   int               hits = 0;

   function automatic byte_type pattern_byte(int k);
      if (k >= PatBytes) return '0;
      return pattern_words[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic int active_length();
      int n;
      n = int'(length_reg);
      if (n > MaxPattern) n = MaxPattern;
      return n;
   endfunction

   // Row for the empty text: only leading "x*" pairs can match.
   function automatic row_type empty_text_row(int n);
      row_type r;
      r = '0;
      r[0] = 1'b1;
      for (int j = 2; j <= n; j += 2) r[j] = r[j-2] && (pattern_byte(j - 1) == StarByte);
      return r;
   endfunction

   function automatic row_type advance_row(row_type prev, byte_type c, int n);
      row_type  cur;
      byte_type p, q;
      cur = '0;
      for (int j = 1; j <= n; j++) begin
         p = pattern_byte(j - 1);
         if (p == StarByte) begin
            // A star with nothing in front of it never matches.
            if (j >= 2) begin
               q = pattern_byte(j - 2);
               cur[j] = (prev[j] && (c == q || q == DotByte)) || cur[j-2];
            end
         end else if (c == p || p == DotByte) begin
            cur[j] = prev[j-1];
         end
      end
      return cur;
   endfunction

   always @(posedge clock) begin : watch
      int               n;
      row_type          start_row;
      match_result_type want, got;
      if (reset) begin
         length_reg = '0;
         foreach (pattern_words[w]) pattern_words[w] = '0;
         match_row = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CsrLength: length_reg = csr_wdata[LenW-1:0];
               CsrBytes0: pattern_words[0] = csr_wdata;
               CsrBytes1: pattern_words[1] = csr_wdata;
               CsrBytes2: pattern_words[2] = csr_wdata;
               CsrBytes3: pattern_words[3] = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            n = active_length();
            if (req_tuser[1]) begin
               // An empty text leaves the stored row alone.
               start_row = empty_text_row(n);
               want.matched = start_row[n];
               want.final_result = 1'b1;
            end else begin
               start_row = req_tuser[0] ? empty_text_row(n) : match_row;
               match_row = advance_row(start_row, req_tdata, n);
               want.matched = match_row[n];
               want.final_result = req_tlast;
            end
            expected_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.matched = rsp_tdata[0];
            got.final_result = rsp_tlast;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("Unexpected result word: matched=%0b final_result=%0b",
                           got.matched, got.final_result);
            end else begin
               want = expected_results.pop_front();
               if (got.matched !== want.matched || got.final_result !== want.final_result) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: expected matched=%0b final_result=%0b, got %0b %0b",
                              want.matched, want.final_result, got.matched, got.final_result);
               end
               if (got.matched === 1'b1) hits++;
            end
         end
      end
      error_count <= errors;
      pending <= expected_results.size();
      hit_count <= hits;
   end

endmodule

### sim/testbench.sv
// Top of the matcher testbench: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
   import wrm_pkg::*;

   localparam int ResetCycles = 6;
   localparam int RandomItems = 600;
   // The last stretch of the random part runs with no gaps and no stalls.
   localparam int CalmItems   = 100;
   // A word needs at most one walk over the pattern, and a result can sit
   // behind a receiver stall, so this is ample to drain.
   localparam int DrainCycles = 2 * MaxPattern;
   localparam int CycleLimit  = 500000;

   localparam byte_type LetterA = "a";

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = '0;   // [7:0] text_byte
   logic [1:0]         req_tuser = '0;   // [0] first_byte, [1] empty_text
   logic               req_tlast = 1'b0; // last_byte
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // [0] matched, [7:1] zero
   logic               rsp_tlast;        // final_result
   logic               csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [WordW-1:0]   csr_wdata = '0;

   int error_count;
   int pending;
   int hit_count;

   // Pattern bytes as the next load will write them; bytes past the length
   // hold junk on purpose, since the block must ignore them.
   byte_type pattern_image [PatBytes];
   byte_type text_buf [$];

   int words_sent = 0;
   int pattern_loads = 0;
   int texts_sent = 0;
   int cycle_count = 0;
   int ready_run = 0;
   int gap_pct = 25;
   bit calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wildcard_regex_matcher_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wildcard_match_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending),
      .hit_count   (hit_count)
   );

   // Result back-pressure. The receiver alternates between ready stretches
   // and stalls; long ready stretches give runs with no idling at all.
   // Near the end it simply stays ready.
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         ready_run <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
         ready_run <= $urandom_range(0, 47);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one word and hold it until the block takes it. The valid stays
   // high afterwards so that back-to-back words need no extra edge; an idle
   // gap is inserted in front of the word at random.
   task automatic send_word(byte_type data, bit first_flag, bit last_flag, bit empty_flag);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= {empty_flag, first_flag};
      req_tlast <= last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Stop sending and wait until every result has come back. The first edge
   // lets the checker register a word that was taken at this very edge.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // One register write per edge; the caller lowers the write enable.
   task automatic write_csr(csr_idx_type idx, logic [WordW-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Registers are only written once the block has gone idle. All five are
   // written on every load, so the word registers see every setting.
   task automatic load_pattern(int len_field);
      logic [WordW-1:0] word;
      wait_idle();
      write_csr(CsrLength, WordW'(len_field));
      for (int w = 0; w < PatWords; w++) begin
         for (int b = 0; b < 8; b++) word[b*8 +: 8] = pattern_image[w*8 + b];
         write_csr(csr_idx_type'(CsrBytes0 + w), word);
      end
      csr_we <= 1'b0;
      pattern_loads++;
   endtask

   function automatic void set_pattern(string s);
      for (int j = 0; j < PatBytes; j++) pattern_image[j] = (j < s.len()) ? s[j] : 8'h00;
   endfunction

   // Text bytes come mostly from a three-letter alphabet so that literals in
   // the pattern get hit; now and then any byte at all.
   function automatic byte_type text_char();
      if ($urandom_range(0, 9) == 0) return byte_type'($urandom);
      return LetterA + byte_type'($urandom_range(0, 2));
   endfunction

   // Random pattern of literals, dots and "x*" pairs. A few patterns start
   // with a lone star, and a random atom may itself be a star or a dot.
   task automatic fill_random_pattern(int target);
      int j;
      for (j = 0; j < PatBytes; j++) pattern_image[j] = byte_type'($urandom);
      j = 0;
      if (target > 0 && $urandom_range(0, 9) == 0) begin
         pattern_image[0] = StarByte;
         j = 1;
      end
      while (j < target) begin
         case ($urandom_range(0, 9))
            0, 1: pattern_image[j] = DotByte;
            2: pattern_image[j] = byte_type'($urandom);
            default: pattern_image[j] = LetterA + byte_type'($urandom_range(0, 2));
         endcase
         j++;
         if (j < target && $urandom_range(0, 2) == 0) begin
            pattern_image[j] = StarByte;
            j++;
         end
      end
   endtask

   // Build a text that the pattern is likely to match: literals copied,
   // dots filled with any text byte, starred atoms repeated zero to three times.
   // Sometimes one byte is then spoiled or an extra byte tacked on.
   task automatic fill_matching_text(int eff);
      int       j;
      byte_type a;
      text_buf.delete();
      j = 0;
      while (j < eff) begin
         a = pattern_image[j];
         if (j + 1 < eff && pattern_image[j+1] == StarByte && a != StarByte) begin
            repeat ($urandom_range(0, 3)) text_buf.push_back(a == DotByte ? text_char() : a);
            j += 2;
         end else begin
            if (a != StarByte) text_buf.push_back(a == DotByte ? text_char() : a);
            j++;
         end
      end
      if (text_buf.size() > 0 && $urandom_range(0, 3) == 0)
         text_buf[$urandom_range(0, text_buf.size() - 1)] = text_char();
      if (text_buf.size() == 0 || $urandom_range(0, 5) == 0) text_buf.push_back(text_char());
   endtask

   task automatic send_text(bit with_first, bit with_last);
      for (int k = 0; k < text_buf.size(); k++)
         send_word(text_buf[k], with_first && k == 0,
                   with_last && k == text_buf.size() - 1, 1'b0);
      texts_sent++;
   endtask

   initial begin : stimulus
      int directed_words;
      int len_field;
      int eff;
      int texts;
      int r;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the pattern is empty and the row is all zero.
      // A word with no first-byte flag just carries on from that row; an
      // empty pattern matches only the empty text.
      send_word(8'h00, 1'b0, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b0, 1'b1);

      // Two starred letters: the empty text matches, and so do runs of them.
      set_pattern("a*b*");
      load_pattern(4);
      send_word(8'hFF, 1'b1, 1'b0, 1'b1);
      send_word("a", 1'b1, 1'b0, 1'b0);
      send_word("a", 1'b0, 1'b0, 1'b0);
      send_word("b", 1'b0, 1'b1, 1'b0);
      send_word("b", 1'b1, 1'b1, 1'b0);
      send_word("c", 1'b1, 1'b1, 1'b0);

      // A star in the first position has nothing to repeat and never matches.
      set_pattern("*a");
      load_pattern(2);
      send_word(8'h00, 1'b0, 1'b1, 1'b1);
      send_word("a", 1'b1, 1'b1, 1'b0);

      // The pattern changes halfway through a text; the stored row carries on
      // against the new pattern.
      set_pattern("ab");
      load_pattern(2);
      send_word("a", 1'b1, 1'b0, 1'b0);
      set_pattern(".b");
      load_pattern(2);
      send_word("b", 1'b0, 1'b1, 1'b0);

      // A full row of ".*" pairs with the largest length field, which the
      // block clips to the row size. Star and dot also show up as text bytes.
      for (int j = 0; j < PatBytes; j++) pattern_image[j] = j[0] ? StarByte : DotByte;
      load_pattern(63);
      send_word(8'h5A, 1'b1, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b0, 1'b0);
      send_word(StarByte, 1'b0, 1'b0, 1'b0);
      send_word(DotByte, 1'b0, 1'b1, 1'b0);

      // All-ones pattern words at full length, then all-zero words.
      foreach (pattern_image[j]) pattern_image[j] = 8'hFF;
      load_pattern(MaxPattern);
      send_word(8'hFF, 1'b1, 1'b1, 1'b0);
      foreach (pattern_image[j]) pattern_image[j] = 8'h00;
      load_pattern(1);
      send_word(8'h00, 1'b1, 1'b1, 1'b0);
      send_word(DotByte, 1'b1, 1'b1, 1'b0);

      directed_words = words_sent;

      // Random part: a fresh pattern per phase, then a handful of texts.
      // Most texts are built to match, the rest are random letters, stray
      // words with random flags, empty texts, and texts with no first byte
      // (those carry the row over, also across a pattern change).
      while (words_sent - directed_words < RandomItems) begin
         r = $urandom_range(0, 19);
         if (r == 0) len_field = MaxPattern;
         else if (r == 1) len_field = $urandom_range(MaxPattern + 1, 63);
         else len_field = $urandom_range(0, 10);
         eff = (len_field > MaxPattern) ? MaxPattern : len_field;
         fill_random_pattern(eff);
         load_pattern(len_field);
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         texts = $urandom_range(3, 10);
         for (int t = 0; t < texts; t++) begin
            calm = (words_sent - directed_words >= RandomItems - CalmItems);
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_word(byte_type'($urandom), 1'($urandom), 1'($urandom), 1'b1);
            end else if (r < 16) begin
               repeat ($urandom_range(1, 4))
                  send_word(byte_type'($urandom), 1'($urandom), 1'($urandom),
                            $urandom_range(0, 9) == 0);
            end else begin
               if (r < 70) begin
                  fill_matching_text(eff);
               end else begin
                  text_buf.delete();
                  repeat ($urandom_range(1, 8)) text_buf.push_back(text_char());
               end
               send_text($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
            end
         end
      end

      wait_idle();
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d words in %0d texts over %0d pattern loads; %0d results matched.",
               words_sent, texts_sent, pattern_loads, hit_count);
      $display("Patterns ranged from empty to clipped full length, with stars, dots and gaps.");
      if (error_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
src/wrm_pkg.sv
src/wrm_ram.sv
src/wrm_pattern_regs.sv
src/wrm_scan.sv
src/wildcard_regex_matcher_unit.sv
src/wrm_checker.sv
sim/wildcard_match_checker.sv
sim/testbench.sv
